@@ hw/rtl/pmb_pkg.sv @@
// Package for the ping-pong message buffer: item and result types, codes, defaults.
// No dependencies; imported by pmb_ctrl and ping_pong_message_buffer.
`timescale 1ns / 1ps
`default_nettype none

package pmb_pkg;

    localparam int BANK_DEPTH_DEF  = 1024;
    localparam int MAX_MESSAGE_DEF = 255;
    localparam int CFG_W           = 11;
    localparam logic [CFG_W-1:0] BANK_SIZE_RST = 11'd1024;

    typedef enum logic [1:0] {
        KIND_WR_START = 2'd0,
        KIND_WR_BYTE  = 2'd1,
        KIND_RD_START = 2'd2,
        KIND_RD_BYTE  = 2'd3
    } pmb_kind_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NO_SPACE  = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_TOO_LARGE = 3'd3,
        STAT_BUSY      = 3'd4,
        STAT_SEQ       = 3'd5
    } pmb_status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } pmb_state_t;

    typedef struct packed {
        pmb_kind_t   kind;
        logic [7:0]  data_in;
        logic [7:0]  length;
    } pmb_item_t;

    typedef struct packed {
        pmb_status_t status;
        logic [7:0]  data_out;
        logic [7:0]  msg_length;
        logic        last_byte;
    } pmb_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/pmb_bank_ram.sv @@
// Byte-wide bank memory holding both banks: one write port, one registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module pmb_bank_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pmb_ctrl.sv @@
// Control for the ping-pong message buffer: bank fills, read head, open flags, bank swap,
// item sequencing and the output register. Uses pmb_pkg; drives pmb_bank_ram.
`timescale 1ns / 1ps
`default_nettype none

module pmb_ctrl #(
    parameter int BANK_DEPTH  = pmb_pkg::BANK_DEPTH_DEF,
    parameter int MAX_MESSAGE = pmb_pkg::MAX_MESSAGE_DEF,
    parameter int ADDR_W      = $clog2(2 * BANK_DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [pmb_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire pmb_pkg::pmb_item_t        in_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output pmb_pkg::pmb_result_t           out_result,
    output logic                           mem_we,
    output logic      [ADDR_W-1:0]         mem_waddr,
    output logic      [7:0]                mem_wdata,
    output logic                           mem_re,
    output logic      [ADDR_W-1:0]         mem_raddr,
    input  wire logic [7:0]                mem_rdata
);

    import pmb_pkg::*;

    localparam int FILL_W = $clog2(BANK_DEPTH + 1);
    localparam int OFF_W  = $clog2(BANK_DEPTH);
    localparam int CW     = ((FILL_W > CFG_W) ? FILL_W : CFG_W) + 1;

    pmb_state_t        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    pmb_result_t       out_result_reg, out_result_next;
    pmb_item_t         item_reg;
    logic [CFG_W-1:0]  bank_size_reg;
    logic [FILL_W-1:0] fill_reg [2];
    logic [FILL_W-1:0] fill_next [2];
    logic              rsel_reg, rsel_next;
    logic [FILL_W-1:0] head_reg, head_next;
    logic [7:0]        wrem_reg, wrem_next;
    logic              wopen_reg, wopen_next;
    logic [7:0]        rrem_reg, rrem_next;
    logic              ropen_reg, ropen_next;
    logic              swap_reg, swap_next;

    logic              commit;
    logic              rd_empty;
    logic              rd_go;
    logic              close_w;
    logic              drain_chk;
    logic              wb;
    logic [CW-1:0]     cap;
    logic [CW-1:0]     need;
    logic              rd_swap_addr;
    logic              rd_bank;
    logic [OFF_W-1:0]  rd_off;
    pmb_result_t       res;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    assign wb       = ~rsel_reg;
    assign rd_empty = (head_reg >= fill_reg[rsel_reg]);
    assign cap      = (CW'(bank_size_reg) > CW'(BANK_DEPTH)) ? CW'(BANK_DEPTH)
                                                             : CW'(bank_size_reg);
    assign need     = CW'(fill_reg[wb]) + CW'(1) + CW'(item_reg.length);

    assign mem_waddr = ADDR_W'(fill_reg[wb][OFF_W-1:0])
                     + (wb ? ADDR_W'(BANK_DEPTH) : ADDR_W'(0));
    assign mem_wdata = (item_reg.kind == KIND_WR_START) ? item_reg.length : item_reg.data_in;

    assign rd_swap_addr = (in_item.kind == KIND_RD_START) && rd_empty;
    assign rd_bank      = rd_swap_addr ? ~rsel_reg : rsel_reg;
    assign rd_off       = rd_swap_addr ? '0 : head_reg[OFF_W-1:0];
    assign mem_raddr    = ADDR_W'(rd_off) + (rd_bank ? ADDR_W'(BANK_DEPTH) : ADDR_W'(0));
    assign mem_re       = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        fill_next       = fill_reg;
        rsel_next       = rsel_reg;
        head_next       = head_reg;
        wrem_next       = wrem_reg;
        wopen_next      = wopen_reg;
        rrem_next       = rrem_reg;
        ropen_next      = ropen_reg;
        swap_next       = swap_reg;
        commit          = 1'b0;
        mem_we          = 1'b0;
        rd_go           = 1'b0;
        close_w         = 1'b0;
        drain_chk       = 1'b0;
        res             = '{status: STAT_OK, data_out: 8'd0, msg_length: 8'd0,
                            last_byte: 1'b0};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit)
        begin
            case (item_reg.kind)
                KIND_WR_START:
                begin
                    if (wopen_reg)
                    begin
                        res.status = STAT_SEQ;
                    end
                    else if (item_reg.length > 8'(MAX_MESSAGE))
                    begin
                        res.status = STAT_TOO_LARGE;
                    end
                    else if (need > cap)
                    begin
                        res.status = STAT_NO_SPACE;
                    end
                    else
                    begin
                        mem_we        = 1'b1;
                        fill_next[wb] = fill_reg[wb] + FILL_W'(1);
                        wrem_next     = item_reg.length;
                        wopen_next    = 1'b1;
                        close_w       = (item_reg.length == 8'd0);
                    end
                end
                KIND_WR_BYTE:
                begin
                    if (!wopen_reg)
                    begin
                        res.status = STAT_SEQ;
                    end
                    else
                    begin
                        mem_we        = 1'b1;
                        fill_next[wb] = fill_reg[wb] + FILL_W'(1);
                        wrem_next     = wrem_reg - 8'd1;
                        close_w       = (wrem_next == 8'd0);
                    end
                end
                KIND_RD_START:
                begin
                    if (ropen_reg)
                    begin
                        res.status = STAT_SEQ;
                    end
                    else if (rd_empty && wopen_reg)
                    begin
                        res.status = STAT_BUSY;
                    end
                    else
                    begin
                        rd_go = 1'b1;
                        if (rd_empty)
                        begin
                            fill_next[rsel_reg] = '0;
                            rsel_next           = ~rsel_reg;
                            head_next           = '0;
                            swap_next           = 1'b0;
                            if (fill_reg[~rsel_reg] == '0)
                            begin
                                res.status = STAT_EMPTY;
                                rd_go      = 1'b0;
                            end
                        end
                        if (rd_go)
                        begin
                            res.msg_length = mem_rdata;
                            if (mem_rdata > item_reg.length)
                            begin
                                res.status = STAT_TOO_LARGE;
                            end
                            else
                            begin
                                head_next  = head_next + FILL_W'(1);
                                rrem_next  = mem_rdata;
                                ropen_next = (mem_rdata != 8'd0);
                                drain_chk  = (mem_rdata == 8'd0);
                            end
                        end
                    end
                end
                KIND_RD_BYTE:
                begin
                    if (!ropen_reg)
                    begin
                        res.status = STAT_SEQ;
                    end
                    else
                    begin
                        res.data_out = mem_rdata;
                        head_next    = head_reg + FILL_W'(1);
                        rrem_next    = rrem_reg - 8'd1;
                        if (rrem_next == 8'd0)
                        begin
                            res.last_byte = 1'b1;
                            ropen_next    = 1'b0;
                            drain_chk     = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res.status = STAT_SEQ;
                end
            endcase

            // close the write; take a deferred swap
            if (close_w)
            begin
                wopen_next = 1'b0;
                if (swap_reg)
                begin
                    rsel_next = ~rsel_next;
                    head_next = '0;
                    swap_next = 1'b0;
                end
            end

            // drain the read bank; swap now or defer behind an open write
            if (drain_chk && (head_next >= fill_next[rsel_next]))
            begin
                fill_next[rsel_next] = '0;
                head_next            = '0;
                if (wopen_next)
                begin
                    swap_next = 1'b1;
                end
                else
                begin
                    rsel_next = ~rsel_next;
                    swap_next = 1'b0;
                end
            end

            out_valid_next  = 1'b1;
            out_result_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bank_size_reg <= BANK_SIZE_RST;
            fill_reg[0]   <= '0;
            fill_reg[1]   <= '0;
            rsel_reg      <= 1'b0;
            head_reg      <= '0;
            wrem_reg      <= '0;
            wopen_reg     <= 1'b0;
            rrem_reg      <= '0;
            ropen_reg     <= 1'b0;
            swap_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                bank_size_reg <= cfg_wdata;
            end
            fill_reg[0]   <= fill_next[0];
            fill_reg[1]   <= fill_next[1];
            rsel_reg      <= rsel_next;
            head_reg      <= head_next;
            wrem_reg      <= wrem_next;
            wopen_reg     <= wopen_next;
            rrem_reg      <= rrem_next;
            ropen_reg     <= ropen_next;
            swap_reg      <= swap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
        if (mem_re)
        begin
            item_reg <= in_item;
        end
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("bank memory read and write in the same cycle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] <= FILL_W'(BANK_DEPTH)) && (fill_reg[1] <= FILL_W'(BANK_DEPTH)))
        else $error("bank fill beyond bank depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= fill_reg[rsel_reg])
        else $error("read head past read bank fill");

    a_swap_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        swap_reg |-> wopen_reg)
        else $error("deferred swap with no open write");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed transaction produced no result");

endmodule

`default_nettype wire

@@ hw/rtl/ping_pong_message_buffer.sv @@
// Timing: an accepted transaction registers its item and bank read and enters ST_EXEC;
//   the result is registered from ST_EXEC once the output register is free.
// Transactions do not overlap: one is taken only in ST_IDLE, as the registered bank
//   read precedes each state update; a stalled result holds the block after one more.
// Reset: control state, fills and flags clear, bank_size returns to 1024; bank memory
//   contents are not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module ping_pong_message_buffer #(
    parameter int BANK_DEPTH  = pmb_pkg::BANK_DEPTH_DEF,
    parameter int MAX_MESSAGE = pmb_pkg::MAX_MESSAGE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [pmb_pkg::CFG_W-1:0] cfg_wdata,     // bank_size
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [15:0]               s_axis_tdata,  // data_in, length
    input  wire logic [1:0]                s_axis_tuser,  // kind
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [15:0]               m_axis_tdata,  // data_out, msg_length
    output logic      [2:0]                m_axis_tuser,  // status
    output logic                           m_axis_tlast   // last_byte
);

    import pmb_pkg::*;

    localparam int ADDR_W = $clog2(2 * BANK_DEPTH);

    pmb_item_t         item;
    pmb_result_t       result;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    assign item.kind    = pmb_kind_t'(s_axis_tuser);
    assign item.data_in = s_axis_tdata[7:0];
    assign item.length  = s_axis_tdata[15:8];

    assign m_axis_tdata = {result.msg_length, result.data_out};
    assign m_axis_tuser = result.status;
    assign m_axis_tlast = result.last_byte;

    pmb_ctrl #(
        .BANK_DEPTH  (BANK_DEPTH),
        .MAX_MESSAGE (MAX_MESSAGE),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    pmb_bank_ram #(
        .DEPTH  (2 * BANK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
